// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain expression that must hold at every clock edge out of reset
`define MUE_ASSERT_COMB(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// temporal property checked at every clock edge out of reset
`define MUE_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/mue_pkg.sv =====
// types, codes and reset values for the terminal context table
`timescale 1ns / 1ps

package mue_pkg;

    localparam int UE_SLOTS_DEF = 256;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REG  = 2'd1;
    localparam logic [1:0] ST_CONN = 2'd2;

    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_DL   = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_POLL = 2'd3;

    localparam logic [7:0] CODE_REQ   = 8'h10;
    localparam logic [7:0] CODE_RESP  = 8'h11;
    localparam logic [7:0] CODE_PAGE  = 8'h15;
    localparam logic [7:0] MASK_RAND  = 8'h01;
    localparam logic [7:0] MASK_SHORT = 8'h02;

    localparam logic [11:0] HOLD_RESET = 12'd500;
    localparam logic [48:0] BASE_RESET = 49'd452040000000001;
    localparam logic [47:0] MS_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  st;
        logic [39:0] sid;
        logic [11:0] hold;
        logic [47:0] dl;
        logic        pend;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        st:   ST_IDLE,
        sid:  40'd0,
        hold: HOLD_RESET,
        dl:   48'd0,
        pend: 1'b1
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  ue_index;
        logic [7:0]  msg_id;
        logic [7:0]  msg_bitmask;
        logic [39:0] msg_short_id;
        logic [11:0] hold_ms;
    } t_item;

    typedef struct packed {
        logic        uplink_valid;
        logic [7:0]  ul_msg_id;
        logic [7:0]  ul_bitmask;
        logic [7:0]  ul_ue_index;
        logic [49:0] ul_identity;
        logic [39:0] ul_short_id;
        logic [1:0]  ue_state_out;
    } t_result;

endpackage

// ===== rtl/core/mue_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module mue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mue_ctx_upd.sv =====
// context update: expiry, init, downlink, poll and the result fields
`timescale 1ns / 1ps

module mue_ctx_upd (
    input  mue_pkg::t_entry  i_entry,
    input  mue_pkg::t_item   i_item,
    input  logic [47:0]      i_now,
    input  logic [48:0]      i_base,
    input  logic             i_in_range,
    output mue_pkg::t_entry  o_entry,
    output mue_pkg::t_result o_result
);

    always_comb begin
        mue_pkg::t_entry  v_e;
        mue_pkg::t_result v_r;
        logic [48:0]      v_sum;

        v_e   = i_entry;
        v_r   = '0;
        v_sum = {1'b0, i_now} + 49'(i_entry.hold);

        // registered entry past its deadline drops back to idle
        if (v_e.st == mue_pkg::ST_REG && v_e.dl != 48'd0 && i_now >= v_e.dl) begin
            v_e.st   = mue_pkg::ST_IDLE;
            v_e.pend = 1'b0;
            v_e.dl   = 48'd0;
        end

        case (i_item.mode)
            mue_pkg::MODE_INIT: begin
                v_e      = mue_pkg::ENTRY_RESET;
                v_e.hold = i_item.hold_ms;
            end
            mue_pkg::MODE_DL: begin
                if (v_e.st != mue_pkg::ST_CONN) begin
                    if (i_item.msg_id == mue_pkg::CODE_RESP) begin
                        if (v_e.st == mue_pkg::ST_IDLE && v_e.sid == 40'd0 &&
                            i_item.msg_bitmask == mue_pkg::MASK_RAND) begin
                            v_e.sid = i_item.msg_short_id;
                            v_e.st  = mue_pkg::ST_REG;
                            v_e.dl  = v_sum[48] ? mue_pkg::MS_MAX : v_sum[47:0];
                        end else if (v_e.st == mue_pkg::ST_IDLE &&
                                     i_item.msg_bitmask == mue_pkg::MASK_SHORT) begin
                            v_e.st = mue_pkg::ST_CONN;
                        end
                    end else if (i_item.msg_id == mue_pkg::CODE_PAGE) begin
                        if (i_item.msg_short_id == v_e.sid) begin
                            v_e.pend = 1'b1;
                            if (v_e.st == mue_pkg::ST_REG) begin
                                v_e.st = mue_pkg::ST_IDLE;
                                v_e.dl = 48'd0;
                            end
                        end
                    end
                end
            end
            mue_pkg::MODE_POLL: begin
                if (v_e.st == mue_pkg::ST_IDLE && v_e.pend) begin
                    v_r.uplink_valid = 1'b1;
                    v_r.ul_msg_id    = mue_pkg::CODE_REQ;
                    v_r.ul_bitmask   = (v_e.sid == 40'd0) ? mue_pkg::MASK_RAND
                                                          : mue_pkg::MASK_SHORT;
                    v_r.ul_ue_index  = i_item.ue_index;
                    v_r.ul_identity  = 50'(i_base) + 50'(i_item.ue_index);
                    v_r.ul_short_id  = v_e.sid;
                    v_e.pend         = 1'b0;
                end
            end
            default: begin
            end
        endcase

        v_r.ue_state_out = v_e.st;

        o_entry  = v_e;
        o_result = i_in_range ? v_r : '0;
    end

endmodule

// ===== rtl/core/multi_ue_attach_paging_fsm_top.sv =====
// top level: terminal context table with attach / paging control and ms clock
`timescale 1ns / 1ps
// from input transaction to result in the output register: ram read when the item is
// accepted, update and write-back once the output register can take the result
// no new item is taken until the last one has been read and written back in the context ram
// output register lets the next item enter while a result still waits downstream
// reset: synchronous, active low; then a clearing pass writes every context to its
// reset value, input ready stays low, config writes still taken

`include "assert_macros.svh"

module multi_ue_attach_paging_fsm_top #(
    parameter int UE_SLOTS = mue_pkg::UE_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config: identity_base
    input  logic          i_cfg_wr_en,
    input  logic [48:0]   i_cfg_wr_data,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // ue_index[7:0], msg_id[15:8], msg_bitmask[23:16], msg_short_id[63:24],
    // hold_ms[75:64], zero pad[79:76]
    input  logic [79:0]   s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]    s_axis_tuser,
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // ul_msg_id[7:0], ul_bitmask[15:8], ul_ue_index[23:16], ul_identity[73:24],
    // ul_short_id[113:74], ue_state_out[115:114], zero pad[119:116]
    output logic [119:0]  m_axis_tdata,
    // uplink_valid
    output logic          m_axis_tuser
);

    localparam int AW = (UE_SLOTS > 1) ? $clog2(UE_SLOTS) : 1;
    localparam int EW = $bits(mue_pkg::t_entry);

    // control states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [47:0]       r_now;
    logic [48:0]       r_base;
    logic              r_out_valid;
    mue_pkg::t_result  r_out;
    mue_pkg::t_item    r_item;
    logic              r_in_range;

    mue_pkg::t_item    w_item;
    logic              w_in_range;
    logic              w_accept;
    logic              w_commit;
    logic [47:0]       w_now_eff;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [EW-1:0]     w_ram_wdata;
    logic [EW-1:0]     w_ram_rdata;
    mue_pkg::t_entry   w_upd_entry;
    mue_pkg::t_result  w_upd_res;

    // unpack the input transaction
    assign w_item.mode         = s_axis_tuser;
    assign w_item.ue_index     = s_axis_tdata[7:0];
    assign w_item.msg_id       = s_axis_tdata[15:8];
    assign w_item.msg_bitmask  = s_axis_tdata[23:16];
    assign w_item.msg_short_id = s_axis_tdata[63:24];
    assign w_item.hold_ms      = s_axis_tdata[75:64];

    // index past the table touches no entry
    assign w_in_range = ({24'd0, w_item.ue_index} < 32'(UE_SLOTS));

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // write-back happens once the output register can take the result
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // tick advances the clock before the expiry check, saturating at the top
    assign w_now_eff = (r_item.mode == mue_pkg::MODE_TICK && r_now != mue_pkg::MS_MAX)
                       ? r_now + 48'd1 : r_now;

    // ram write: clearing pass after reset, else the updated context
    assign w_ram_we    = (r_state == S_CLEAR) || (w_commit && r_in_range);
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : AW'(r_item.ue_index);
    assign w_ram_wdata = (r_state == S_CLEAR) ? EW'(mue_pkg::ENTRY_RESET) : EW'(w_upd_entry);

    mue_ram #(
        .WIDTH (EW),
        .DEPTH (UE_SLOTS)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept && w_in_range),
        .i_raddr (AW'(w_item.ue_index)),
        .o_rdata (w_ram_rdata)
    );

    mue_ctx_upd u_ctx_upd (
        .i_entry    (mue_pkg::t_entry'(w_ram_rdata)),
        .i_item     (r_item),
        .i_now      (w_now_eff),
        .i_base     (r_base),
        .i_in_range (r_in_range),
        .o_entry    (w_upd_entry),
        .o_result   (w_upd_res)
    );

    // state sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(UE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_now       <= 48'd0;
            r_base      <= mue_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (w_commit) begin
                r_now       <= w_now_eff;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item     <= w_item;
            r_in_range <= w_in_range;
        end
        if (w_commit) begin
            r_out <= w_upd_res;
        end
    end

    // pack the result transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.uplink_valid;
    assign m_axis_tdata  = {4'd0, r_out.ue_state_out, r_out.ul_short_id, r_out.ul_identity,
                            r_out.ul_ue_index, r_out.ul_bitmask, r_out.ul_msg_id};

    // checks
    `MUE_ASSERT_COMB(a_no_accept_in_clear, r_state != S_CLEAR || !s_axis_tready, "ready in clear")
    `MUE_ASSERT_COMB(a_ram_write_ctx, !w_ram_we || r_state != S_IDLE, "ram write while idle")
    `MUE_ASSERT_PROP(a_accept_to_exec, w_accept |=> (r_state == S_EXEC), "accept without execute")
    `MUE_ASSERT_PROP(a_clock_only_on_commit, (!w_commit) |=> (r_now == $past(r_now)), "clock moved")

endmodule
